// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the enclosing-circle RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is asserted
`define TEC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check built on the plain form
`define TEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `TEC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/tec_pkg.sv =====
// Types and constants for the three-point enclosing circle pipeline.
// No dependencies.
`default_nettype none

package tec_pkg;

    localparam int PT_W    = 20;  // Q12.8 coordinate
    localparam int DF_W    = 21;  // coordinate difference
    localparam int PR_W    = 42;  // product of two differences
    localparam int NUM_W   = 64;  // divider numerator / remainder
    localparam int DEN_W   = 42;  // divider denominator, 2*|cross|
    localparam int DIV_QW  = 22;  // quotient bits, one per stage
    localparam int SQ_IN_W = 42;  // squared distance
    localparam int SQ_STG  = 21;  // root bits, one per stage
    localparam int RAD_W   = 21;  // radius field
    localparam int OFF_W   = 24;  // rounded circumcentre offset

    typedef logic signed [PT_W-1:0]  t_pt;
    typedef logic signed [DF_W-1:0]  t_df;
    typedef logic signed [PR_W-1:0]  t_pr;
    typedef logic signed [OFF_W-1:0] t_off;

    // which centre the item ends up with
    typedef enum logic [1:0] {
        SEL_AB,
        SEL_AC,
        SEL_BC,
        SEL_CIRC
    } t_sel;

    typedef struct packed {
        t_pt ax;
        t_pt ay;
        t_pt bx;
        t_pt by;
        t_pt cx;
        t_pt cy;
    } t_tri;

    // data that rides alongside the dividers
    typedef struct packed {
        t_sel sel;
        t_pt  mid_x;
        t_pt  mid_y;
        logic neg_x;
        logic neg_y;
        t_tri pts;
    } t_side;

    // divider operands
    typedef struct packed {
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [DEN_W-1:0] den;
    } t_div_req;

endpackage

`default_nettype wire

// ===== rtl/tec_if.sv =====
// Valid/ready channel interfaces for point-triple items and circle items.
// Depends on tec_pkg.
`default_nettype none

interface tec_in_if import tec_pkg::*; ();
    logic valid;
    logic ready;
    t_pt  ax;
    t_pt  ay;
    t_pt  bx;
    t_pt  by_coord;
    t_pt  cx;
    t_pt  cy;

    modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
    modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface tec_out_if import tec_pkg::*; ();
    logic             valid;
    logic             ready;
    t_pt              center_x;
    t_pt              center_y;
    logic [RAD_W-1:0] radius;

    modport source (output valid, center_x, center_y, radius, input ready);
    modport sink   (input valid, center_x, center_y, radius, output ready);
endinterface

`default_nettype wire

// ===== rtl/tec_front.sv =====
// Front end: differences, dot/cross products, case selection and the
// circumcentre numerators, six register stages. Depends on tec_pkg.
`default_nettype none

module tec_front
    import tec_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_tri     i_tri,
    output logic          o_valid,
    output t_side         o_side,
    output t_div_req      o_req
);

    // midpoint rounded to nearest, ties up
    function automatic t_pt mid2(input t_pt a, input t_pt b);
        t_df s;
        s = DF_W'(a) + DF_W'(b) + t_df'(1);
        return s[DF_W-1:1];
    endfunction

    // stage 1: differences and midpoints
    logic r1_v;
    t_df  r1_ux, r1_uy, r1_vx, r1_vy;
    t_pt  r1_mabx, r1_maby, r1_macx, r1_macy, r1_mbcx, r1_mbcy;
    t_tri r1_tri;

    // stage 2: products
    logic r2_v;
    t_pr  r2_pxx, r2_pyy, r2_qxx, r2_qyy, r2_dxx, r2_dyy, r2_c1, r2_c2;
    t_df  r2_ux, r2_uy, r2_vx, r2_vy;
    t_pt  r2_mabx, r2_maby, r2_macx, r2_macy, r2_mbcx, r2_mbcy;
    t_tri r2_tri;

    // stage 3: lengths, dot and cross
    logic r3_v;
    t_pr  r3_lab, r3_lac, r3_dot, r3_crs;
    t_df  r3_ux, r3_uy, r3_vx, r3_vy;
    t_pt  r3_mabx, r3_maby, r3_macx, r3_macy, r3_mbcx, r3_mbcy;
    t_tri r3_tri;

    // stage 4: selection and partial products
    logic                      r4_v;
    t_sel                      r4_sel;
    logic signed [PR_W-1:0]    r4_vlh, r4_ulh, r4_xlh, r4_wlh;
    logic signed [PR_W:0]      r4_vll, r4_ull, r4_xll, r4_wll;
    t_pr                       r4_crs;
    t_pt                       r4_midx, r4_midy;
    t_tri                      r4_tri;

    // stage 5: numerators
    logic                      r5_v;
    t_sel                      r5_sel;
    logic signed [NUM_W-1:0]   r5_nx, r5_ny;
    t_pr                       r5_crs;
    t_pt                       r5_midx, r5_midy;
    t_tri                      r5_tri;

    // stage 6: magnitudes for the dividers
    logic      r6_v;
    t_side     r6_side;
    t_div_req  r6_req;

    // combinational helpers
    t_sel                    n4_sel;
    t_pt                     n4_midx, n4_midy;
    logic signed [DF_W-1:0]  w_lab_hi, w_lac_hi;
    logic signed [DF_W:0]    w_lab_lo, w_lac_lo;
    logic [NUM_W-1:0]        n6_numx, n6_numy;
    logic [DEN_W-1:0]        n6_den;
    t_pr                     w_abs_crs;
    logic                    n6_negx, n6_negy;

    // centre selection from the exact integer tests
    always_comb begin
        if (r3_crs == '0) begin
            if (r3_dot > 0) begin
                n4_sel = (r3_lab > r3_lac) ? SEL_AB : SEL_AC;
            end else begin
                n4_sel = SEL_BC;
            end
        end else if (r3_lab < r3_dot) begin
            n4_sel = SEL_AC;
        end else if (r3_lac < r3_dot) begin
            n4_sel = SEL_AB;
        end else if (r3_dot < 0) begin
            n4_sel = SEL_BC;
        end else begin
            n4_sel = SEL_CIRC;
        end
        case (n4_sel)
            SEL_AB: begin
                n4_midx = r3_mabx;
                n4_midy = r3_maby;
            end
            SEL_AC: begin
                n4_midx = r3_macx;
                n4_midy = r3_macy;
            end
            SEL_BC: begin
                n4_midx = r3_mbcx;
                n4_midy = r3_mbcy;
            end
            default: begin
                n4_midx = r3_mabx;
                n4_midy = r3_maby;
            end
        endcase
    end

    // lengths are non-negative; split them for narrow multipliers
    assign w_lab_hi = $signed({1'b0, r3_lab[PR_W-2:DF_W]});
    assign w_lac_hi = $signed({1'b0, r3_lac[PR_W-2:DF_W]});
    assign w_lab_lo = $signed({1'b0, r3_lab[DF_W-1:0]});
    assign w_lac_lo = $signed({1'b0, r3_lac[DF_W-1:0]});

    // sign split ahead of unsigned division
    always_comb begin
        w_abs_crs = r5_crs[PR_W-1] ? -r5_crs : r5_crs;
        if (r5_sel == SEL_CIRC) begin
            n6_numx = r5_nx[NUM_W-1] ? NUM_W'(-r5_nx) : NUM_W'(r5_nx);
            n6_numy = r5_ny[NUM_W-1] ? NUM_W'(-r5_ny) : NUM_W'(r5_ny);
            n6_den  = {w_abs_crs[PR_W-2:0], 1'b0};
            n6_negx = r5_nx[NUM_W-1] ^ r5_crs[PR_W-1];
            n6_negy = r5_ny[NUM_W-1] ^ r5_crs[PR_W-1];
        end else begin
            n6_numx = '0;
            n6_numy = '0;
            n6_den  = DEN_W'(1);
            n6_negx = 1'b0;
            n6_negy = 1'b0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ux   <= DF_W'(i_tri.bx) - DF_W'(i_tri.ax);
            r1_uy   <= DF_W'(i_tri.by) - DF_W'(i_tri.ay);
            r1_vx   <= DF_W'(i_tri.cx) - DF_W'(i_tri.ax);
            r1_vy   <= DF_W'(i_tri.cy) - DF_W'(i_tri.ay);
            r1_mabx <= mid2(i_tri.ax, i_tri.bx);
            r1_maby <= mid2(i_tri.ay, i_tri.by);
            r1_macx <= mid2(i_tri.ax, i_tri.cx);
            r1_macy <= mid2(i_tri.ay, i_tri.cy);
            r1_mbcx <= mid2(i_tri.bx, i_tri.cx);
            r1_mbcy <= mid2(i_tri.by, i_tri.cy);
            r1_tri  <= i_tri;

            r2_pxx  <= PR_W'(r1_ux) * PR_W'(r1_ux);
            r2_pyy  <= PR_W'(r1_uy) * PR_W'(r1_uy);
            r2_qxx  <= PR_W'(r1_vx) * PR_W'(r1_vx);
            r2_qyy  <= PR_W'(r1_vy) * PR_W'(r1_vy);
            r2_dxx  <= PR_W'(r1_ux) * PR_W'(r1_vx);
            r2_dyy  <= PR_W'(r1_uy) * PR_W'(r1_vy);
            r2_c1   <= PR_W'(r1_ux) * PR_W'(r1_vy);
            r2_c2   <= PR_W'(r1_uy) * PR_W'(r1_vx);
            r2_ux   <= r1_ux;
            r2_uy   <= r1_uy;
            r2_vx   <= r1_vx;
            r2_vy   <= r1_vy;
            r2_mabx <= r1_mabx;
            r2_maby <= r1_maby;
            r2_macx <= r1_macx;
            r2_macy <= r1_macy;
            r2_mbcx <= r1_mbcx;
            r2_mbcy <= r1_mbcy;
            r2_tri  <= r1_tri;

            r3_lab  <= r2_pxx + r2_pyy;
            r3_lac  <= r2_qxx + r2_qyy;
            r3_dot  <= r2_dxx + r2_dyy;
            r3_crs  <= r2_c1 - r2_c2;
            r3_ux   <= r2_ux;
            r3_uy   <= r2_uy;
            r3_vx   <= r2_vx;
            r3_vy   <= r2_vy;
            r3_mabx <= r2_mabx;
            r3_maby <= r2_maby;
            r3_macx <= r2_macx;
            r3_macy <= r2_macy;
            r3_mbcx <= r2_mbcx;
            r3_mbcy <= r2_mbcy;
            r3_tri  <= r2_tri;

            r4_sel  <= n4_sel;
            r4_vlh  <= PR_W'(r3_vy) * PR_W'(w_lab_hi);
            r4_vll  <= (PR_W+1)'(r3_vy) * (PR_W+1)'(w_lab_lo);
            r4_ulh  <= PR_W'(r3_uy) * PR_W'(w_lac_hi);
            r4_ull  <= (PR_W+1)'(r3_uy) * (PR_W+1)'(w_lac_lo);
            r4_xlh  <= PR_W'(r3_ux) * PR_W'(w_lac_hi);
            r4_xll  <= (PR_W+1)'(r3_ux) * (PR_W+1)'(w_lac_lo);
            r4_wlh  <= PR_W'(r3_vx) * PR_W'(w_lab_hi);
            r4_wll  <= (PR_W+1)'(r3_vx) * (PR_W+1)'(w_lab_lo);
            r4_crs  <= r3_crs;
            r4_midx <= n4_midx;
            r4_midy <= n4_midy;
            r4_tri  <= r3_tri;

            // nx = vy*lab - uy*lac, ny = ux*lac - vx*lab
            r5_nx   <= (NUM_W'(r4_vlh) <<< DF_W) + NUM_W'(r4_vll)
                     - (NUM_W'(r4_ulh) <<< DF_W) - NUM_W'(r4_ull);
            r5_ny   <= (NUM_W'(r4_xlh) <<< DF_W) + NUM_W'(r4_xll)
                     - (NUM_W'(r4_wlh) <<< DF_W) - NUM_W'(r4_wll);
            r5_sel  <= r4_sel;
            r5_crs  <= r4_crs;
            r5_midx <= r4_midx;
            r5_midy <= r4_midy;
            r5_tri  <= r4_tri;

            r6_side.sel   <= r5_sel;
            r6_side.mid_x <= r5_midx;
            r6_side.mid_y <= r5_midy;
            r6_side.neg_x <= n6_negx;
            r6_side.neg_y <= n6_negy;
            r6_side.pts   <= r5_tri;
            r6_req.num_x  <= n6_numx;
            r6_req.num_y  <= n6_numy;
            r6_req.den    <= n6_den;
        end
    end

    assign o_valid = r6_v;
    assign o_side  = r6_side;
    assign o_req   = r6_req;

endmodule

`default_nettype wire

// ===== rtl/tec_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on tec_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tec_div
    import tec_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_valid,
    output logic [DIV_QW-1:0]     o_quot,
    output logic [DEN_W-1:0]      o_rem,
    output logic [DEN_W-1:0]      o_den
);

    logic                r_v   [DIV_QW];
    logic [NUM_W-1:0]    r_rem [DIV_QW];
    logic [DEN_W-1:0]    r_den [DIV_QW];
    logic [DIV_QW-1:0]   r_q   [DIV_QW];

    logic [NUM_W-1:0]    w_rem_in [DIV_QW];
    logic [DEN_W-1:0]    w_den_in [DIV_QW];
    logic [DIV_QW-1:0]   w_q_in   [DIV_QW];
    logic                w_v_in   [DIV_QW];
    logic [NUM_W-1:0]    n_rem    [DIV_QW];
    logic [DIV_QW-1:0]   n_q      [DIV_QW];

    // stage inputs: port for the first, previous register otherwise
    always_comb begin
        w_rem_in[0] = i_num;
        w_den_in[0] = i_den;
        w_q_in[0]   = '0;
        w_v_in[0]   = i_valid;
        for (int k = 1; k < DIV_QW; k++) begin
            w_rem_in[k] = r_rem[k-1];
            w_den_in[k] = r_den[k-1];
            w_q_in[k]   = r_q[k-1];
            w_v_in[k]   = r_v[k-1];
        end
    end

    // one compare-subtract per stage against the shifted divisor
    always_comb begin
        logic [NUM_W-1:0] trial;
        logic             ge;
        for (int k = 0; k < DIV_QW; k++) begin
            trial    = NUM_W'(w_den_in[k]) << (DIV_QW - 1 - k);
            ge       = (w_rem_in[k] >= trial);
            n_rem[k] = ge ? (w_rem_in[k] - trial) : w_rem_in[k];
            n_q[k]   = {w_q_in[k][DIV_QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_QW; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < DIV_QW; k++) begin
                r_v[k] <= w_v_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= w_den_in[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_valid = r_v[DIV_QW-1];
    assign o_quot  = r_q[DIV_QW-1];
    assign o_rem   = r_rem[DIV_QW-1][DEN_W-1:0];
    assign o_den   = r_den[DIV_QW-1];

    // quotient must have fitted: final remainder below the divisor
    `TEC_ASSERT_IMP(a_div_rem_small, i_clk, i_rst_n, r_v[DIV_QW-1],
        r_rem[DIV_QW-1] < NUM_W'(r_den[DIV_QW-1]), "divider remainder not below divisor")

endmodule

`default_nettype wire

// ===== rtl/tec_radius.sv =====
// Radius back end: squared distances, maximum, pipelined square root
// rounded up, and the output register. Depends on tec_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tec_radius
    import tec_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_pt         i_cx,
    input  wire t_pt         i_cy,
    input  wire t_tri        i_tri,
    output logic             o_valid,
    output t_pt              o_cx,
    output t_pt              o_cy,
    output logic [RAD_W-1:0] o_radius
);

    typedef struct packed {
        t_pt cx;
        t_pt cy;
    } t_ctr;

    // stage 1: distances along each axis
    logic r1_v;
    t_df  r1_dax, r1_day, r1_dbx, r1_dby, r1_dcx, r1_dcy;
    t_ctr r1_c;
    // stage 2: squares
    logic r2_v;
    t_pr  r2_sax, r2_say, r2_sbx, r2_sby, r2_scx, r2_scy;
    t_ctr r2_c;
    // stage 3: squared distances
    logic r3_v;
    t_pr  r3_ma, r3_mb, r3_mc;
    t_ctr r3_c;
    // stage 4: largest one
    logic               r4_v;
    logic [SQ_IN_W-1:0] r4_m;
    t_ctr               r4_c;

    // square root stages
    logic               r_v    [SQ_STG];
    logic [SQ_IN_W-1:0] r_rem  [SQ_STG];
    logic [SQ_IN_W-1:0] r_root [SQ_STG];
    t_ctr               r_c    [SQ_STG];

    logic               w_v_in    [SQ_STG];
    logic [SQ_IN_W-1:0] w_rem_in  [SQ_STG];
    logic [SQ_IN_W-1:0] w_root_in [SQ_STG];
    t_ctr               w_c_in    [SQ_STG];
    logic [SQ_IN_W-1:0] n_rem     [SQ_STG];
    logic [SQ_IN_W-1:0] n_root    [SQ_STG];

    // output register
    logic               r_o_v;
    t_pt                r_o_cx, r_o_cy;
    logic [RAD_W-1:0]   r_o_rad;

    t_pr                n4_mab;
    logic [SQ_IN_W-1:0] n_rad;

    assign n4_mab = (r3_mb > r3_ma) ? r3_mb : r3_ma;

    always_comb begin
        w_rem_in[0]  = r4_m;
        w_root_in[0] = '0;
        w_v_in[0]    = r4_v;
        w_c_in[0]    = r4_c;
        for (int k = 1; k < SQ_STG; k++) begin
            w_rem_in[k]  = r_rem[k-1];
            w_root_in[k] = r_root[k-1];
            w_v_in[k]    = r_v[k-1];
            w_c_in[k]    = r_c[k-1];
        end
    end

    // digit-by-digit root, one result bit per stage
    always_comb begin
        logic [SQ_IN_W-1:0] bitv;
        logic [SQ_IN_W-1:0] trial;
        logic               ge;
        for (int k = 0; k < SQ_STG; k++) begin
            bitv      = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k);
            trial     = w_root_in[k] + bitv;
            ge        = (w_rem_in[k] >= trial);
            n_rem[k]  = ge ? (w_rem_in[k] - trial) : w_rem_in[k];
            n_root[k] = ge ? ((w_root_in[k] >> 1) + bitv) : (w_root_in[k] >> 1);
        end
    end

    // round up when anything is left over
    assign n_rad = r_root[SQ_STG-1] + SQ_IN_W'(r_rem[SQ_STG-1] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r_o_v <= 1'b0;
            for (int k = 0; k < SQ_STG; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r_o_v <= r_v[SQ_STG-1];
            for (int k = 0; k < SQ_STG; k++) begin
                r_v[k] <= w_v_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dax  <= DF_W'(i_cx) - DF_W'(i_tri.ax);
            r1_day  <= DF_W'(i_cy) - DF_W'(i_tri.ay);
            r1_dbx  <= DF_W'(i_cx) - DF_W'(i_tri.bx);
            r1_dby  <= DF_W'(i_cy) - DF_W'(i_tri.by);
            r1_dcx  <= DF_W'(i_cx) - DF_W'(i_tri.cx);
            r1_dcy  <= DF_W'(i_cy) - DF_W'(i_tri.cy);
            r1_c.cx <= i_cx;
            r1_c.cy <= i_cy;

            r2_sax  <= PR_W'(r1_dax) * PR_W'(r1_dax);
            r2_say  <= PR_W'(r1_day) * PR_W'(r1_day);
            r2_sbx  <= PR_W'(r1_dbx) * PR_W'(r1_dbx);
            r2_sby  <= PR_W'(r1_dby) * PR_W'(r1_dby);
            r2_scx  <= PR_W'(r1_dcx) * PR_W'(r1_dcx);
            r2_scy  <= PR_W'(r1_dcy) * PR_W'(r1_dcy);
            r2_c    <= r1_c;

            r3_ma   <= r2_sax + r2_say;
            r3_mb   <= r2_sbx + r2_sby;
            r3_mc   <= r2_scx + r2_scy;
            r3_c    <= r2_c;

            r4_m    <= $unsigned((r3_mc > n4_mab) ? r3_mc : n4_mab);
            r4_c    <= r3_c;

            for (int k = 0; k < SQ_STG; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_c[k]    <= w_c_in[k];
            end

            r_o_cx  <= r_c[SQ_STG-1].cx;
            r_o_cy  <= r_c[SQ_STG-1].cy;
            r_o_rad <= n_rad[RAD_W-1:0];
        end
    end

    assign o_valid  = r_o_v;
    assign o_cx     = r_o_cx;
    assign o_cy     = r_o_cy;
    assign o_radius = r_o_rad;

    // integer root invariant: v - root^2 never exceeds 2*root
    `TEC_ASSERT_IMP(a_sqrt_rem_bound, i_clk, i_rst_n, r_v[SQ_STG-1],
        (SQ_IN_W+1)'(r_rem[SQ_STG-1]) <= ((SQ_IN_W+1)'(r_root[SQ_STG-1]) << 1), "root remainder out of range")

endmodule

`default_nettype wire

// ===== rtl/three_point_enclosing_circle_core.sv =====
// Throughput one item per cycle while no result is held waiting at the output.
// Built around the 22-stage quotient pipeline and the 21-stage square-root pipeline.
// One stall signal holds every stage while a result waits at the output.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
// Depends on tec_pkg, tec_if, tec_front, tec_div, tec_radius, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module three_point_enclosing_circle_core
    import tec_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tec_in_if.sink    i_in,
    tec_out_if.source o_out
);

    logic     w_en;
    t_tri     w_tri;
    logic     w_f_v;
    t_side    w_f_side;
    t_div_req w_f_req;

    logic              w_dx_v, w_dy_v;
    logic [DIV_QW-1:0] w_qx, w_qy;
    logic [DEN_W-1:0]  w_rx, w_ry, w_dx_den, w_dy_den;

    t_side r_dl [DIV_QW];

    // rounding stage
    logic  r_rd_v;
    t_off  r_rd_offx, r_rd_offy;
    t_side r_rd_side;
    // centre stage
    logic  r_ct_v;
    t_pt   r_ct_x, r_ct_y;
    t_tri  r_ct_tri;

    logic  w_o_v;
    t_off  n_offx, n_offy;

    // whole pipeline moves unless a result is waiting
    assign w_en       = !w_o_v || o_out.ready;
    assign i_in.ready = w_en;

    assign w_tri.ax = i_in.ax;
    assign w_tri.ay = i_in.ay;
    assign w_tri.bx = i_in.bx;
    assign w_tri.by = i_in.by_coord;
    assign w_tri.cx = i_in.cx;
    assign w_tri.cy = i_in.cy;

    tec_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_tri   (w_tri),
        .o_valid (w_f_v),
        .o_side  (w_f_side),
        .o_req   (w_f_req)
    );

    tec_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_num   (w_f_req.num_x),
        .i_den   (w_f_req.den),
        .o_valid (w_dx_v),
        .o_quot  (w_qx),
        .o_rem   (w_rx),
        .o_den   (w_dx_den)
    );

    tec_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_num   (w_f_req.num_y),
        .i_den   (w_f_req.den),
        .o_valid (w_dy_v),
        .o_quot  (w_qy),
        .o_rem   (w_ry),
        .o_den   (w_dy_den)
    );

    // round to nearest, ties toward plus infinity, on sign and magnitude
    always_comb begin
        logic                up_x, up_y;
        logic [DIV_QW:0]     mag_x, mag_y;
        up_x   = r_dl[DIV_QW-1].neg_x ? ({w_rx, 1'b0} >  (DEN_W+1)'(w_dx_den))
                                      : ({w_rx, 1'b0} >= (DEN_W+1)'(w_dx_den));
        up_y   = r_dl[DIV_QW-1].neg_y ? ({w_ry, 1'b0} >  (DEN_W+1)'(w_dy_den))
                                      : ({w_ry, 1'b0} >= (DEN_W+1)'(w_dy_den));
        mag_x  = (DIV_QW+1)'(w_qx) + (DIV_QW+1)'(up_x);
        mag_y  = (DIV_QW+1)'(w_qy) + (DIV_QW+1)'(up_y);
        n_offx = r_dl[DIV_QW-1].neg_x ? -$signed(OFF_W'(mag_x)) : $signed(OFF_W'(mag_x));
        n_offy = r_dl[DIV_QW-1].neg_y ? -$signed(OFF_W'(mag_y)) : $signed(OFF_W'(mag_y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_ct_v <= 1'b0;
        end else if (w_en) begin
            r_rd_v <= w_dx_v;
            r_ct_v <= r_rd_v;
        end
    end

    // side data delay matching the divider depth, then round and centre
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[0] <= w_f_side;
            for (int k = 1; k < DIV_QW; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
            r_rd_offx <= n_offx;
            r_rd_offy <= n_offy;
            r_rd_side <= r_dl[DIV_QW-1];
            if (r_rd_side.sel == SEL_CIRC) begin
                r_ct_x <= PT_W'(OFF_W'(r_rd_side.pts.ax) + r_rd_offx);
                r_ct_y <= PT_W'(OFF_W'(r_rd_side.pts.ay) + r_rd_offy);
            end else begin
                r_ct_x <= r_rd_side.mid_x;
                r_ct_y <= r_rd_side.mid_y;
            end
            r_ct_tri <= r_rd_side.pts;
        end
    end

    tec_radius u_radius (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_ct_v),
        .i_cx     (r_ct_x),
        .i_cy     (r_ct_y),
        .i_tri    (r_ct_tri),
        .o_valid  (w_o_v),
        .o_cx     (o_out.center_x),
        .o_cy     (o_out.center_y),
        .o_radius (o_out.radius)
    );

    assign o_out.valid = w_o_v;

    // both dividers stay in lock step
    `TEC_ASSERT(a_div_lockstep, i_clk, i_rst_n, w_dx_v == w_dy_v, "dividers out of step")

endmodule

`default_nettype wire

// ===== test/tb_three_point_enclosing_circle_core.sv =====
// Testbench for three_point_enclosing_circle_core: drives point triples, predicts each circle.
// Depends on tec_pkg, tec_if and the core; the predictor works in exact integer arithmetic.
`default_nettype none

module tb_three_point_enclosing_circle_core;
    import tec_pkg::*;

    // expected circle
    typedef struct packed {
        logic [19:0] cx;
        logic [19:0] cy;
        logic [20:0] rad;
    } t_circle;

    // round n/d to nearest, ties up; d > 0 after sign fold
    function automatic longint div_round(longint n, longint d);
        longint q, r;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        q = n / d;
        r = n % d;
        if (r < 0) begin
            q = q - 1;
            r = r + d;
        end
        if (2 * r >= d) q = q + 1;
        return q;
    endfunction

    function automatic longint root_up(longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (mid * mid >= v) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic longint dsq(longint px, longint py, longint qx, longint qy);
        return (px - qx) * (px - qx) + (py - qy) * (py - qy);
    endfunction

    function automatic t_circle enclose(t_tri p);
        longint ax, ay, bx, by, cx, cy, ux, uy, vx, vy, lab, lac, dt, cr, ox, oy, m, q;
        t_circle c;
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by; cx = p.cx; cy = p.cy;
        ux = bx - ax; uy = by - ay; vx = cx - ax; vy = cy - ay;
        lab = ux * ux + uy * uy;
        lac = vx * vx + vy * vy;
        dt  = ux * vx + uy * vy;
        cr  = ux * vy - uy * vx;
        if (cr == 0) begin
            if (dt > 0 && lab > lac) begin
                ox = div_round(ax + bx, 2); oy = div_round(ay + by, 2);
            end else if (dt > 0) begin
                ox = div_round(ax + cx, 2); oy = div_round(ay + cy, 2);
            end else begin
                ox = div_round(bx + cx, 2); oy = div_round(by + cy, 2);
            end
        end else if (lab < dt) begin
            ox = div_round(ax + cx, 2); oy = div_round(ay + cy, 2);
        end else if (lac < dt) begin
            ox = div_round(ax + bx, 2); oy = div_round(ay + by, 2);
        end else if (dt < 0) begin
            ox = div_round(bx + cx, 2); oy = div_round(by + cy, 2);
        end else begin
            ox = ax + div_round(vy * lab - uy * lac, 2 * cr);
            oy = ay + div_round(ux * lac - vx * lab, 2 * cr);
        end
        m = dsq(ox, oy, ax, ay);
        q = dsq(ox, oy, bx, by);
        if (q > m) m = q;
        q = dsq(ox, oy, cx, cy);
        if (q > m) m = q;
        c.cx  = ox[19:0];
        c.cy  = oy[19:0];
        c.rad = 21'(root_up(m));
        return c;
    endfunction

    // scoreboard of pending circles
    class circle_board;
        t_circle pending[$];
        int      errors;

        function void note_triple(t_tri p);
            pending.push_back(enclose(p));
        endfunction

        function void check_circle(t_circle got);
            t_circle exp_c;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item cx=%h cy=%h r=%h", $time,
                         got.cx, got.cy, got.rad);
                errors++;
                return;
            end
            exp_c = pending.pop_front();
            if (got.cx !== exp_c.cx) begin
                $display("%0t: center_x expected %h actual %h", $time, exp_c.cx, got.cx);
                errors++;
            end
            if (got.cy !== exp_c.cy) begin
                $display("%0t: center_y expected %h actual %h", $time, exp_c.cy, got.cy);
                errors++;
            end
            if (got.rad !== exp_c.rad) begin
                $display("%0t: radius expected %h actual %h", $time, exp_c.rad, got.rad);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    tec_in_if  tri_ch ();
    tec_out_if circ_ch ();

    three_point_enclosing_circle_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (tri_ch.sink),
        .o_out  (circ_ch.source)
    );

    circle_board board;
    int          cycles;
    bit          calm;      // no idling in the closing part
    bit          sink_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb_three_point_enclosing_circle_core failed");
            $finish;
        end
    end

    // result side: random stall bursts, check on accept
    initial begin
        int n;
        circ_ch.ready = 1'b0;
        wait (sink_on);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 11);
                circ_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            circ_ch.ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) begin
                @(posedge i_clk);
                if (circ_ch.valid && circ_ch.ready)
                    board.check_circle({circ_ch.center_x, circ_ch.center_y, circ_ch.radius});
            end
        end
    end

    function automatic logic [19:0] any_pt();
        case ($urandom_range(0, 5))
            0: return 20'h80000;
            1: return 20'h7FFFF;
            2: return 20'(int'($urandom_range(0, 400)) - 200);
            default: return 20'($urandom);
        endcase
    endfunction

    // one triple, held until accepted; valid stays high between back-to-back items
    task automatic send_triple(t_tri p);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 11);
            tri_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        tri_ch.valid    <= 1'b1;
        tri_ch.ax       <= p.ax;
        tri_ch.ay       <= p.ay;
        tri_ch.bx       <= p.bx;
        tri_ch.by_coord <= p.by;
        tri_ch.cx       <= p.cx;
        tri_ch.cy       <= p.cy;
        do @(posedge i_clk); while (!tri_ch.ready);
        board.note_triple(p);
    endtask

    task automatic send_pts(longint ax, longint ay, longint bx, longint by,
                            longint cx, longint cy);
        t_tri p;
        p.ax = ax[19:0]; p.ay = ay[19:0]; p.bx = bx[19:0];
        p.by = by[19:0]; p.cx = cx[19:0]; p.cy = cy[19:0];
        send_triple(p);
    endtask

    initial begin
        t_tri   p;
        longint k, ox, oy, dx, dy;
        board           = new();
        calm            = 1'b0;
        sink_on         = 1'b0;
        i_rst_n         = 1'b0;
        tri_ch.valid    = 1'b0;
        tri_ch.ax       = '0;
        tri_ch.ay       = '0;
        tri_ch.bx       = '0;
        tri_ch.by_coord = '0;
        tri_ch.cx       = '0;
        tri_ch.cy       = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1'b1;

        // directed: coincident, collinear branches, obtuse at each corner, circumcentre
        send_pts(0, 0, 0, 0, 0, 0);
        send_pts(-524288, -524288, -524288, -524288, -524288, -524288);
        send_pts(524287, 524287, 524287, 524287, 524287, 524287);
        send_pts(0, 0, 10, 0, 5, 0);
        send_pts(0, 0, 5, 0, 10, 0);
        send_pts(0, 0, 7, 7, 7, 7);
        send_pts(0, 0, -3, 0, 9, 0);
        send_pts(-524288, -524288, 524287, 524287, 0, 0);
        send_pts(-524288, 524287, 524287, -524288, 1, -1);
        send_pts(0, 0, 1, 0, 0, 1);
        send_pts(0, 0, 100, 0, -1, 50);
        send_pts(0, 0, 100, 1, 50, -2);
        send_pts(0, 0, 100, 0, 50, 3);
        send_pts(0, 0, 3, 101, 100, 0);
        send_pts(-524288, -524288, 524287, -524288, 0, 524287);
        send_pts(524287, -524288, -524288, 524287, 524287, 524287);
        send_pts(-524288, 0, 524287, 1, 3, 2);
        send_pts(1, 1, 2, 3, 5, 7);
        send_pts(-7, 3, 11, -5, 2, 19);

        // random: mostly general, some collinear and near-degenerate
        for (int i = 0; i < 730; i++) begin
            if (i == 365) begin
                // drain the pipeline with the input idle
                tri_ch.valid <= 1'b0;
                while (board.pending.size() != 0) @(posedge i_clk);
            end
            if (i >= 650) calm = 1'b1;
            case ($urandom_range(0, 4))
                0: begin
                    ox = $signed(any_pt()); oy = $signed(any_pt());
                    dx = $urandom_range(0, 200) - 100; dy = $urandom_range(0, 200) - 100;
                    k  = $urandom_range(0, 8) - 4;
                    p.ax = ox[19:0]; p.ay = oy[19:0];
                    p.bx = 20'(ox + dx); p.by = 20'(oy + dy);
                    p.cx = 20'(ox + k * dx); p.cy = 20'(oy + k * dy);
                end
                1: begin
                    ox = $urandom_range(0, 2000) - 1000; oy = $urandom_range(0, 2000) - 1000;
                    p.ax = ox[19:0]; p.ay = oy[19:0];
                    p.bx = 20'(ox + $urandom_range(0, 6) - 3);
                    p.by = 20'(oy + $urandom_range(0, 6) - 3);
                    p.cx = 20'(ox + $urandom_range(0, 6) - 3);
                    p.cy = 20'(oy + $urandom_range(0, 6) - 3);
                end
                default: begin
                    p.ax = any_pt(); p.ay = any_pt(); p.bx = any_pt();
                    p.by = any_pt(); p.cx = any_pt(); p.cy = any_pt();
                end
            endcase
            send_triple(p);
        end
        tri_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_three_point_enclosing_circle_core passed");
        else
            $display("tb_three_point_enclosing_circle_core failed");
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/tec_pkg.sv
rtl/tec_if.sv
rtl/tec_front.sv
rtl/tec_div.sv
rtl/tec_radius.sv
rtl/three_point_enclosing_circle_core.sv
test/tb_three_point_enclosing_circle_core.sv
